FILE: rtl/core/cau_pkg.sv
// Shared constants and codes of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

endpackage

FILE: rtl/core/cau_if.sv
// Request and response channel interfaces of the complex arithmetic unit.
`timescale 1ns / 1ps
interface cau_req_if #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic signed [DATA_WIDTH-1:0] first_real;
   logic signed [DATA_WIDTH-1:0] first_imag;
   logic signed [DATA_WIDTH-1:0] second_real;
   logic signed [DATA_WIDTH-1:0] second_imag;

   modport source (output valid, command, first_real, first_imag, second_real, second_imag,
                   input ready);
   modport sink (input valid, command, first_real, first_imag, second_real, second_imag,
                 output ready);
endinterface

interface cau_rsp_if #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_real;
   logic signed [DATA_WIDTH-1:0] result_imag;
   logic [1:0]                   status;

   modport source (output valid, result_real, result_imag, status, input ready);
   modport sink (input valid, result_real, result_imag, status, output ready);
endinterface

FILE: rtl/core/complex_arith_unit_top.sv
// Top level of the pipelined complex arithmetic unit (add, sub, mul, div).
`timescale 1ns / 1ps
// Usage
// - req_bus carries one beat per operation: command plus two complex operands,
//   signed fixed point with FRAC_BITS fraction bits in DATA_WIDTH bits.
// - rsp_bus returns one beat per request, in order: the rounded, saturated
//   result and a status (ok, overflow saturated, divide by zero).
// - Every command passes through the same pipeline; its depth is set by
//   the restoring divider, one quotient bit per stage.
// - Unstalled, a new request may enter every cycle: one beat per cycle.
// - Each stage holds a valid bit; a stage loads whenever it is empty or its
//   successor moves, so bubbles are squeezed out during a stall.
// - When the receiver stalls, the last stage holds its beat and the pipe
//   fills up behind it; req ready drops only once every stage is full.
// - Synchronous reset clears all valid bits; the data path is not reset.
// - Multiply and divide round to nearest, ties away from zero. A zero
//   divisor returns zero with divide-by-zero status.
module complex_arith_unit_top #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_bus,
   cau_rsp_if.source rsp_bus
);

   localparam int W    = DATA_WIDTH;
   localparam int RW   = 3 * W + FRAC_BITS + 2;     // divider remainder width
   localparam int NSTG = W + 5;                     // pipeline depth
   localparam int DIV0 = 3;                         // first quotient-bit stage

   localparam logic [2*W:0] MAX_POS  = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [2*W:0] MAX_NEG  = {{(W + 1){1'b0}}, 1'b1, {(W - 1){1'b0}}};
   localparam logic [2*W:0] HALF_LSB = (2 * W + 1)'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      cau_pkg::cmd_type          cmd;
      logic signed [2*W-1:0]     prod_ac;
      logic signed [2*W-1:0]     prod_bd;
      logic signed [2*W-1:0]     prod_ad;
      logic signed [2*W-1:0]     prod_bc;
      logic signed [2*W-1:0]     prod_cc;
      logic signed [2*W-1:0]     prod_dd;
      logic signed [W:0]         asum_re;
      logic signed [W:0]         asum_im;
      logic                      neg_re;
      logic                      neg_im;
      logic [2*W-1:0]            mag_re;
      logic [2*W-1:0]            mag_im;
      logic [2*W-1:0]            den;
      logic                      dz;
      logic                      sat_re;
      logic                      sat_im;
      logic [RW-1:0]             rem_re;
      logic [RW-1:0]             rem_im;
      logic [W:0]                q_re;
      logic [W:0]                q_im;
      logic [W-1:0]              res_re;
      logic [W-1:0]              res_im;
      logic                      ovf_re;
      logic                      ovf_im;
      cau_pkg::status_type       status;
   } pipe_type;

   pipe_type pipe_ff [NSTG];
   pipe_type pipe_in [NSTG];
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] go;

   // {overflow, value}: saturate a sign-magnitude value to W bits
   function automatic logic [W:0] clamp_fn(input logic neg, input logic [2*W:0] mag);
      logic [W-1:0] low;
      low = mag[W-1:0];
      if (!neg) begin
         if (mag > MAX_POS) clamp_fn = {1'b1, MAX_POS[W-1:0]};
         else               clamp_fn = {1'b0, low};
      end else begin
         if (mag > MAX_NEG) clamp_fn = {1'b1, MAX_NEG[W-1:0]};
         else               clamp_fn = {1'b0, -low};
      end
   endfunction

   // stage i loads when empty or when its beat moves on
   always_comb begin
      go[NSTG-1] = !vld_ff[NSTG-1] || rsp_bus.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         go[i] = !vld_ff[i] || go[i+1];
      end
      vld_in[0] = go[0] ? req_bus.valid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = go[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_bus.ready = go[0];

   // stage 0: operand products and add/sub sums
   always_comb begin
      logic signed [W-1:0] a, b, c, d;
      a = req_bus.first_real;
      b = req_bus.first_imag;
      c = req_bus.second_real;
      d = req_bus.second_imag;
      pipe_in[0] = '0;
      pipe_in[0].cmd = cau_pkg::cmd_type'(req_bus.command);
      pipe_in[0].prod_ac = (2 * W)'(a) * (2 * W)'(c);
      pipe_in[0].prod_bd = (2 * W)'(b) * (2 * W)'(d);
      pipe_in[0].prod_ad = (2 * W)'(a) * (2 * W)'(d);
      pipe_in[0].prod_bc = (2 * W)'(b) * (2 * W)'(c);
      pipe_in[0].prod_cc = (2 * W)'(c) * (2 * W)'(c);
      pipe_in[0].prod_dd = (2 * W)'(d) * (2 * W)'(d);
      if (req_bus.command == cau_pkg::CMD_SUB) begin
         pipe_in[0].asum_re = (W + 1)'(a) - (W + 1)'(c);
         pipe_in[0].asum_im = (W + 1)'(b) - (W + 1)'(d);
      end else begin
         pipe_in[0].asum_re = (W + 1)'(a) + (W + 1)'(c);
         pipe_in[0].asum_im = (W + 1)'(b) + (W + 1)'(d);
      end
   end

   // stage 1: cross-product sums to sign-magnitude, divisor norm
   always_comb begin
      logic signed [2*W:0] sre, sim;
      pipe_in[1] = pipe_ff[0];
      if (pipe_ff[0].cmd == cau_pkg::CMD_MUL) begin
         sre = (2 * W + 1)'(pipe_ff[0].prod_ac) - (2 * W + 1)'(pipe_ff[0].prod_bd);
         sim = (2 * W + 1)'(pipe_ff[0].prod_ad) + (2 * W + 1)'(pipe_ff[0].prod_bc);
      end else begin
         sre = (2 * W + 1)'(pipe_ff[0].prod_ac) + (2 * W + 1)'(pipe_ff[0].prod_bd);
         sim = (2 * W + 1)'(pipe_ff[0].prod_bc) - (2 * W + 1)'(pipe_ff[0].prod_ad);
      end
      pipe_in[1].neg_re = sre[2*W];
      pipe_in[1].neg_im = sim[2*W];
      pipe_in[1].mag_re = sre[2*W] ? (2 * W)'(-sre) : sre[2*W-1:0];
      pipe_in[1].mag_im = sim[2*W] ? (2 * W)'(-sim) : sim[2*W-1:0];
      pipe_in[1].den = pipe_ff[0].prod_cc[2*W-1:0] + pipe_ff[0].prod_dd[2*W-1:0];
      pipe_in[1].dz = (pipe_in[1].den == '0);
   end

   // stage 2: finish add/sub/mul; set up the divider
   always_comb begin
      logic [W:0]    amag_re, amag_im, cre, cim;
      logic [2*W:0]  mre, mim;
      logic [RW-1:0] num_re, num_im, lim;
      pipe_in[2] = pipe_ff[1];
      amag_re = pipe_ff[1].asum_re[W] ? (W + 1)'(-pipe_ff[1].asum_re) : pipe_ff[1].asum_re;
      amag_im = pipe_ff[1].asum_im[W] ? (W + 1)'(-pipe_ff[1].asum_im) : pipe_ff[1].asum_im;
      mre = ({1'b0, pipe_ff[1].mag_re} + HALF_LSB) >> FRAC_BITS;
      mim = ({1'b0, pipe_ff[1].mag_im} + HALF_LSB) >> FRAC_BITS;
      if (pipe_ff[1].cmd == cau_pkg::CMD_MUL) begin
         cre = clamp_fn(pipe_ff[1].neg_re, mre);
         cim = clamp_fn(pipe_ff[1].neg_im, mim);
      end else begin
         cre = clamp_fn(pipe_ff[1].asum_re[W], (2 * W + 1)'(amag_re));
         cim = clamp_fn(pipe_ff[1].asum_im[W], (2 * W + 1)'(amag_im));
      end
      pipe_in[2].ovf_re = cre[W];
      pipe_in[2].res_re = cre[W-1:0];
      pipe_in[2].ovf_im = cim[W];
      pipe_in[2].res_im = cim[W-1:0];
      num_re = RW'(pipe_ff[1].mag_re) << (FRAC_BITS + 1);
      num_im = RW'(pipe_ff[1].mag_im) << (FRAC_BITS + 1);
      lim    = RW'(pipe_ff[1].den) << (W + 1);
      // quotient too large for W+1 bits: saturates whatever the remainder
      pipe_in[2].sat_re = (num_re >= lim);
      pipe_in[2].sat_im = (num_im >= lim);
      pipe_in[2].rem_re = pipe_in[2].sat_re ? '0 : num_re;
      pipe_in[2].rem_im = pipe_in[2].sat_im ? '0 : num_im;
      pipe_in[2].q_re = '0;
      pipe_in[2].q_im = '0;
   end

   // restoring divider, one quotient bit per stage, MSB first
   for (genvar i = DIV0; i <= DIV0 + W; i++) begin : g_div
      localparam int K = W - (i - DIV0);
      always_comb begin
         logic [RW-1:0] dk;
         pipe_in[i] = pipe_ff[i-1];
         dk = RW'(pipe_ff[i-1].den) << K;
         if (pipe_ff[i-1].rem_re >= dk) begin
            pipe_in[i].rem_re = pipe_ff[i-1].rem_re - dk;
            pipe_in[i].q_re[K] = 1'b1;
         end
         if (pipe_ff[i-1].rem_im >= dk) begin
            pipe_in[i].rem_im = pipe_ff[i-1].rem_im - dk;
            pipe_in[i].q_im[K] = 1'b1;
         end
      end
   end

   // last stage: round the quotient, saturate, status
   always_comb begin
      logic [W+1:0] rre, rim;
      logic [W:0]   cre, cim;
      pipe_in[NSTG-1] = pipe_ff[NSTG-2];
      rre = {1'b0, pipe_ff[NSTG-2].q_re} + (W + 2)'(1);
      rim = {1'b0, pipe_ff[NSTG-2].q_im} + (W + 2)'(1);
      cre = pipe_ff[NSTG-2].sat_re ? clamp_fn(pipe_ff[NSTG-2].neg_re, MAX_NEG + 1'b1)
                                   : clamp_fn(pipe_ff[NSTG-2].neg_re && rre[W+1:1] != '0,
                                              (2 * W + 1)'(rre[W+1:1]));
      cim = pipe_ff[NSTG-2].sat_im ? clamp_fn(pipe_ff[NSTG-2].neg_im, MAX_NEG + 1'b1)
                                   : clamp_fn(pipe_ff[NSTG-2].neg_im && rim[W+1:1] != '0,
                                              (2 * W + 1)'(rim[W+1:1]));
      if (pipe_ff[NSTG-2].cmd == cau_pkg::CMD_DIV) begin
         pipe_in[NSTG-1].ovf_re = cre[W];
         pipe_in[NSTG-1].res_re = cre[W-1:0];
         pipe_in[NSTG-1].ovf_im = cim[W];
         pipe_in[NSTG-1].res_im = cim[W-1:0];
      end
      if (pipe_ff[NSTG-2].cmd == cau_pkg::CMD_DIV && pipe_ff[NSTG-2].dz) begin
         pipe_in[NSTG-1].res_re = '0;
         pipe_in[NSTG-1].res_im = '0;
         pipe_in[NSTG-1].status = cau_pkg::ST_DZ;
      end else if (pipe_in[NSTG-1].ovf_re || pipe_in[NSTG-1].ovf_im) begin
         pipe_in[NSTG-1].status = cau_pkg::ST_OVF;
      end else begin
         pipe_in[NSTG-1].status = cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (go[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_bus.valid       = vld_ff[NSTG-1];
   assign rsp_bus.result_real = pipe_ff[NSTG-1].res_re;
   assign rsp_bus.result_imag = pipe_ff[NSTG-1].res_im;
   assign rsp_bus.status      = pipe_ff[NSTG-1].status;

   // divide-by-zero status only for a divide, and always with a zero result
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTG-1] && pipe_ff[NSTG-1].status == cau_pkg::ST_DZ) |->
      (pipe_ff[NSTG-1].cmd == cau_pkg::CMD_DIV && pipe_ff[NSTG-1].res_re == '0 &&
       pipe_ff[NSTG-1].res_im == '0))
      else $error("divide-by-zero status with non-divide or non-zero result");

   // a quotient caught too large before the divider must report overflow
   a_presat_ovf: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTG-1] && pipe_ff[NSTG-1].cmd == cau_pkg::CMD_DIV && !pipe_ff[NSTG-1].dz &&
       (pipe_ff[NSTG-1].sat_re || pipe_ff[NSTG-1].sat_im)) |->
      (pipe_ff[NSTG-1].status == cau_pkg::ST_OVF))
      else $error("saturated quotient without overflow status");

   // a stalled beat in the last stage stays put
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTG-1] && !rsp_bus.ready) |=> (vld_ff[NSTG-1] && $stable(pipe_ff[NSTG-1])))
      else $error("output beat lost during stall");

   // a full pipe with the receiver stalled must refuse new beats
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while pipeline full and stalled");

endmodule

FILE: verif/complex_arith_unit_checker.sv
// Checker for the complex arithmetic unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module complex_arith_unit_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [1:0] req_command,
   input  logic signed [15:0] req_first_real,
   input  logic signed [15:0] req_first_imag,
   input  logic signed [15:0] req_second_real,
   input  logic signed [15:0] req_second_imag,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic signed [15:0] rsp_result_real,
   input  logic signed [15:0] rsp_result_imag,
   input  logic [1:0] rsp_status,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic signed [15:0]  re;
      logic signed [15:0]  im;
      cau_pkg::status_type st;
   } cplx_result_t;

   localparam longint MAXP = 32767;
   localparam longint MAXN = 32768;

   cplx_result_t expected_results[$];

   // saturate a sign-magnitude value to 16 bits
   function automatic longint sat_sm(input bit neg, input longint unsigned mag,
                                     inout bit ovf);
      if (!neg) begin
         if (mag > MAXP) begin
            ovf = 1;
            return MAXP;
         end
         return mag;
      end
      if (mag > MAXN) begin
         ovf = 1;
         return -MAXN;
      end
      return -longint'(mag);
   endfunction

   // (num << 12) / den rounded to nearest, ties away from zero
   function automatic longint div_round(input longint num, input longint den,
                                        inout bit ovf);
      longint unsigned mag;
      longint unsigned q;
      bit neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      if (q > MAXN) return sat_sm(neg, q, ovf);
      q = ((mag << 13) / den + 1) >> 1;
      return sat_sm(neg && q != 0, q, ovf);
   endfunction

   function automatic longint mul_round(input longint v, inout bit ovf);
      longint unsigned mag;
      mag = v < 0 ? -v : v;
      mag = (mag + 2048) >> 12;
      return sat_sm(v < 0 && mag != 0, mag, ovf);
   endfunction

   function automatic cplx_result_t complex_op(input cau_pkg::cmd_type cmd, input longint a,
                                               input longint b, input longint c,
                                               input longint d);
      cplx_result_t r;
      bit ovf;
      longint re, im, den;
      ovf = 0;
      re = 0;
      im = 0;
      r.st = cau_pkg::ST_OK;
      case (cmd)
         cau_pkg::CMD_ADD: begin
            re = sat_sm(a + c < 0, (a + c < 0) ? -(a + c) : a + c, ovf);
            im = sat_sm(b + d < 0, (b + d < 0) ? -(b + d) : b + d, ovf);
         end
         cau_pkg::CMD_SUB: begin
            re = sat_sm(a - c < 0, (a - c < 0) ? -(a - c) : a - c, ovf);
            im = sat_sm(b - d < 0, (b - d < 0) ? -(b - d) : b - d, ovf);
         end
         cau_pkg::CMD_MUL: begin
            re = mul_round(a * c - b * d, ovf);
            im = mul_round(a * d + b * c, ovf);
         end
         default: begin
            den = c * c + d * d;
            if (den == 0) r.st = cau_pkg::ST_DZ;
            else begin
               re = div_round(a * c + b * d, den, ovf);
               im = div_round(b * c - a * d, den, ovf);
            end
         end
      endcase
      if (r.st == cau_pkg::ST_OK && ovf) r.st = cau_pkg::ST_OVF;
      r.re = re[15:0];
      r.im = im[15:0];
      return r;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      cplx_result_t want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(complex_op(cau_pkg::cmd_type'(req_command),
               req_first_real, req_first_imag, req_second_real, req_second_imag));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result beat");
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (want.re !== rsp_result_real) begin
                  $error("result_real expected %0d actual %0d", want.re, rsp_result_real);
                  errs++;
               end
               if (want.im !== rsp_result_imag) begin
                  $error("result_imag expected %0d actual %0d", want.im, rsp_result_imag);
                  errs++;
               end
               if (want.st !== rsp_status) begin
                  $error("status expected %0d actual %0d", want.st, rsp_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

FILE: verif/complex_arith_unit_top_test.sv
// Testbench top for the complex arithmetic unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module complex_arith_unit_top_test;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   drain_mode;   // no idling in the closing stretch

   cau_req_if req_bus ();
   cau_rsp_if rsp_bus ();

   complex_arith_unit_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   complex_arith_unit_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_command     (req_bus.command),
      .req_first_real  (req_bus.first_real),
      .req_first_imag  (req_bus.first_imag),
      .req_second_real (req_bus.second_real),
      .req_second_imag (req_bus.second_imag),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_result_real (rsp_bus.result_real),
      .rsp_result_imag (rsp_bus.result_imag),
      .rsp_status      (rsp_bus.status),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Receiver side: ready toggles in random bursts until the closing stretch.
   initial begin
      int n;
      rsp_bus.ready = 0;
      forever begin
         @(posedge clock);
         if (drain_mode) begin
            rsp_bus.ready <= 1;
         end else begin
            n = $urandom_range(1, 11);
            rsp_bus.ready <= $urandom_range(0, 2) != 0;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   // Drive one beat; holds valid until accepted. Leaves valid high.
   task automatic send_beat(input cau_pkg::cmd_type cmd, input logic [15:0] a,
                            input logic [15:0] b, input logic [15:0] c,
                            input logic [15:0] d);
      req_bus.valid       <= 1;
      req_bus.command     <= cmd;
      req_bus.first_real  <= a;
      req_bus.first_imag  <= b;
      req_bus.second_real <= c;
      req_bus.second_imag <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Sender gap: now and then lower valid for a random burst.
   task automatic maybe_gap();
      int n;
      if (!drain_mode && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 11);
         req_bus.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Operand picker: mostly random, often an edge value.
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 8191)) - 4096);  // within +-1
         4: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      logic [15:0] edge_vals [5] = '{16'h7fff, 16'h8000, 16'h0000, 16'h1000, 16'hf000};
      logic [15:0] a, b, c, d;
      cau_pkg::cmd_type cmd;
      int k;
      drain_mode = 0;
      reset = 1;
      req_bus.valid = 0;
      req_bus.command = cau_pkg::CMD_ADD;
      req_bus.first_real = 0;
      req_bus.first_imag = 0;
      req_bus.second_real = 0;
      req_bus.second_imag = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: each command over extreme operands, zero divisor, ties
      for (k = 0; k < 20; k++) begin
         cmd = cau_pkg::cmd_type'(k % 4);
         send_beat(cmd, edge_vals[k % 5], edge_vals[(k + 1) % 5], edge_vals[(k + 3) % 5],
                   edge_vals[(k / 4) % 5]);
      end
      send_beat(cau_pkg::CMD_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);  // zero divisor
      send_beat(cau_pkg::CMD_MUL, 16'h0001, 16'h0000, 16'h0800, 16'h0000);  // tie rounds up
      send_beat(cau_pkg::CMD_MUL, 16'hffff, 16'h0000, 16'h0800, 16'h0000);  // tie, negative
      send_beat(cau_pkg::CMD_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);  // tiny quotient
      send_beat(cau_pkg::CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);  // huge quotient

      // pressure point: hold off until the pipe has fully drained
      req_bus.valid <= 0;
      while (pending != 0) @(posedge clock);

      for (k = 0; k < 750; k++) begin
         if (k == 650) drain_mode = 1;
         cmd = cau_pkg::cmd_type'($urandom_range(0, 3));
         a = pick_operand();
         b = pick_operand();
         c = pick_operand();
         d = pick_operand();
         if (cmd == cau_pkg::CMD_DIV && $urandom_range(0, 19) == 0) begin
            c = 0;
            d = 0;
         end
         send_beat(cmd, a, b, c, d);
         maybe_gap();
      end
      req_bus.valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      #200000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
